// ----- rtl/core/dfss_pkg.sv -----
// ----------------------------------------------------------------------------
// dfss_pkg
// Shared types, character codes and helpers for the display frame serializer.
// ----------------------------------------------------------------------------
package dfss_pkg;

    typedef enum logic [2:0] {
        CMD_WRITE  = 3'd0,
        CMD_POLL   = 3'd1,
        CMD_DARK   = 3'd2,
        CMD_TICK   = 3'd3,
        CMD_REPEAT = 3'd4
    } cmd_t;

    localparam logic [7:0]  CHAR_D             = 8'h44;
    localparam logic [7:0]  CHAR_NL            = 8'h0A;
    localparam logic [7:0]  CHAR_ZERO          = 8'h30;
    localparam logic [7:0]  CHAR_A             = 8'h41;
    localparam logic [7:0]  BYTE1_RESET        = 8'h20;
    localparam logic [7:0]  DARK_BIT_MASK      = 8'h40;
    localparam logic [7:0]  BLANK_BYTE1        = 8'h60;
    localparam logic [7:0]  BYTE_ONES          = 8'hFF;
    localparam logic [31:0] IDLE_MAX           = 32'hFFFF_FFFF;
    localparam logic [31:0] DARK_TIMEOUT_RESET = 32'd5000000;

    // Upper-case ASCII hex digit of one nibble.
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] c;
        if (v < 4'd10)
        begin
            c = CHAR_ZERO + {4'd0, v};
        end
        else
        begin
            c = CHAR_A + {4'd0, v} - 8'd10;
        end
        return c;
    endfunction

endpackage

// ----- rtl/core/display_frame_shadow_serializer_unit.sv -----
// ----------------------------------------------------------------------------
// display_frame_shadow_serializer_unit
// Display shadow with dark-mode blanking and an ASCII frame serializer.
// ----------------------------------------------------------------------------
// An item is taken whenever the two-entry frame queue has room, so writes,
// ticks and toggles flow at one per cycle. Each poll that sends a frame, and
// each repeat, queues a snapshot of the frame; the serializer then sends
// 2*NUM_BYTES+2 characters (14 at the default) one per cycle while the output
// is not stalled, through its output register, so a stream of frame-producing
// items is limited by that single character port. A new frame follows the
// previous newline without a gap when one is queued and the output is ready.
module display_frame_shadow_serializer_unit #(
    parameter int NUM_BYTES = 6
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // sector_index[2:0], write_data[10:3],
                                       // write_mask[18:11], zero [23:19]
    input  logic [2:0]  s_axis_tuser,  // cmd[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_char[7:0]
    output logic        m_axis_tlast,  // frame_end
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import dfss_pkg::*;

    logic                   push;
    logic [NUM_BYTES*8-1:0] push_frame;
    logic                   q_full;
    logic                   q_valid;
    logic                   q_pop;
    logic [NUM_BYTES*8-1:0] q_data;

    dfss_front #(
        .NUM_BYTES(NUM_BYTES)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .cmd         (s_axis_tuser),
        .sector_index(s_axis_tdata[2:0]),
        .write_data  (s_axis_tdata[10:3]),
        .write_mask  (s_axis_tdata[18:11]),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .push        (push),
        .push_frame  (push_frame),
        .q_full      (q_full)
    );

    dfss_queue #(
        .WIDTH(NUM_BYTES * 8)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_data(push_frame),
        .full     (q_full),
        .pop      (q_pop),
        .valid    (q_valid),
        .pop_data (q_data)
    );

    dfss_back #(
        .NUM_BYTES(NUM_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .out_valid(m_axis_tvalid),
        .out_ready(m_axis_tready),
        .out_char (m_axis_tdata),
        .frame_end(m_axis_tlast)
    );

endmodule

// ----- rtl/core/dfss_front.sv -----
// ----------------------------------------------------------------------------
// dfss_front
// Accepts items, keeps the display shadow, dark mode and idle timer, and
// pushes a snapshot of every frame that must be sent into the frame queue.
// ----------------------------------------------------------------------------
module dfss_front #(
    parameter int NUM_BYTES = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [2:0]             cmd,
    input  logic [2:0]             sector_index,
    input  logic [7:0]             write_data,
    input  logic [7:0]             write_mask,
    input  logic                   cfg_we,
    input  logic [31:0]            cfg_wdata,
    output logic                   push,
    output logic [NUM_BYTES*8-1:0] push_frame,
    input  logic                   q_full
);
    import dfss_pkg::*;

    logic [NUM_BYTES-1:0][7:0] disp_reg, disp_next;
    logic [NUM_BYTES-1:0][7:0] last_reg, last_next;
    logic [NUM_BYTES-1:0][7:0] blank_frame, reset_frame;
    logic                      dirty_reg, dirty_next;
    logic                      dark_reg, dark_next;
    logic                      blank_reg, blank_next;
    logic [31:0]               idle_reg, idle_next;
    logic [31:0]               timeout_reg;
    logic                      accept;
    logic                      wr_en;
    logic [2:0]                wr_idx;
    logic [7:0]                wr_data;
    logic [7:0]                wr_mask;
    logic [7:0]                new_byte;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;

    // Byte 1 carries the special values; with a single byte there is none.
    always_comb
    begin
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            blank_frame[i] = (i == 1) ? BLANK_BYTE1 : 8'h00;
            reset_frame[i] = (i == 1) ? BYTE1_RESET : 8'h00;
        end
    end

    always_comb
    begin
        disp_next  = disp_reg;
        last_next  = last_reg;
        dirty_next = dirty_reg;
        dark_next  = dark_reg;
        blank_next = blank_reg;
        idle_next  = idle_reg;
        push       = 1'b0;
        wr_en      = 1'b0;
        wr_idx     = sector_index;
        wr_data    = write_data;
        wr_mask    = write_mask;
        new_byte   = 8'h00;
        if (accept)
        begin
            case (cmd_t'(cmd))
                CMD_WRITE:
                begin
                    wr_en = 1'b1;
                end
                CMD_POLL:
                begin
                    if (dirty_reg)
                    begin
                        last_next  = disp_reg;
                        dirty_next = 1'b0;
                        blank_next = 1'b0;
                        push       = 1'b1;
                    end
                    else if (dark_reg && !blank_reg && (idle_reg > timeout_reg))
                    begin
                        last_next  = blank_frame;
                        blank_next = 1'b1;
                        push       = 1'b1;
                    end
                end
                CMD_DARK:
                begin
                    dark_next = !dark_reg;
                    wr_en     = 1'b1;
                    wr_idx    = 3'd1;
                    wr_data   = dark_next ? BYTE_ONES : 8'h00;
                    wr_mask   = DARK_BIT_MASK;
                end
                CMD_TICK:
                begin
                    if (idle_reg != IDLE_MAX)
                    begin
                        idle_next = idle_reg + 32'd1;
                    end
                end
                CMD_REPEAT:
                begin
                    push = 1'b1;
                end
                default:
                begin
                end
            endcase
        end
        // A write only counts as a change when the byte really changes.
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            if (wr_en && (32'(wr_idx) == i))
            begin
                new_byte = (disp_reg[i] & ~wr_mask) | (wr_data & wr_mask);
                if (new_byte != disp_reg[i])
                begin
                    disp_next[i] = new_byte;
                    dirty_next   = 1'b1;
                    idle_next    = 32'd0;
                end
            end
        end
    end

    assign push_frame = last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disp_reg    <= reset_frame;
            last_reg    <= '0;
            dirty_reg   <= 1'b1;
            dark_reg    <= 1'b0;
            blank_reg   <= 1'b0;
            idle_reg    <= 32'd0;
            timeout_reg <= DARK_TIMEOUT_RESET;
        end
        else
        begin
            disp_reg  <= disp_next;
            last_reg  <= last_next;
            dirty_reg <= dirty_next;
            dark_reg  <= dark_next;
            blank_reg <= blank_next;
            idle_reg  <= idle_next;
            if (cfg_we)
            begin
                timeout_reg <= cfg_wdata;
            end
        end
    end

endmodule

// ----- rtl/core/dfss_queue.sv -----
// ----------------------------------------------------------------------------
// dfss_queue
// Two-entry frame queue between the command front and the serializer.
// ----------------------------------------------------------------------------
module dfss_queue #(
    parameter int WIDTH = 48
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             valid,
    output logic [WIDTH-1:0] pop_data
);
    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg, wr_ptr_next;
    logic             rd_ptr_reg, rd_ptr_next;
    logic [1:0]       count_reg, count_next;
    logic             do_push, do_pop;

    assign full     = (count_reg == 2'd2);
    assign valid    = (count_reg != 2'd0);
    assign pop_data = mem[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && valid;

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ----- rtl/core/dfss_back.sv -----
// ----------------------------------------------------------------------------
// dfss_back
// Serializes one queued frame into 'D', two hex digits per byte and a newline,
// one character per cycle through a registered output while not stalled.
// ----------------------------------------------------------------------------
module dfss_back #(
    parameter int NUM_BYTES = 6
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  logic [NUM_BYTES*8-1:0] q_data,
    output logic                   q_pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic [7:0]             out_char,
    output logic                   frame_end
);
    import dfss_pkg::*;

    localparam int NUM_CHARS = 2 * NUM_BYTES + 2;
    localparam int CW        = $clog2(NUM_CHARS);
    localparam logic [CW-1:0] LAST_CHAR = CW'(NUM_CHARS - 1);

    logic [NUM_BYTES-1:0][7:0] frame_reg;
    logic                      busy_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      valid_reg;
    logic [7:0]                char_reg;
    logic                      end_reg;
    logic                      emit;
    logic                      load;
    logic                      is_last;
    logic [CW-1:0]             pos;
    logic [7:0]                sel_byte;
    logic [7:0]                char_next;

    assign emit    = busy_reg && (!valid_reg || out_ready);
    assign is_last = (cnt_reg == LAST_CHAR);
    assign load    = q_valid && (!busy_reg || (emit && is_last));
    assign q_pop   = load;

    always_comb
    begin
        pos      = cnt_reg - CW'(1);
        sel_byte = 8'h00;
        for (int i = 0; i < NUM_BYTES; i++)
        begin
            if (32'(pos[CW-1:1]) == i)
            begin
                sel_byte = frame_reg[i];
            end
        end
        if (cnt_reg == '0)
        begin
            char_next = CHAR_D;
        end
        else if (is_last)
        begin
            char_next = CHAR_NL;
        end
        else if (!pos[0])
        begin
            char_next = hex_char(sel_byte[7:4]);
        end
        else
        begin
            char_next = hex_char(sel_byte[3:0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            frame_reg <= q_data;
        end
        if (emit)
        begin
            char_reg <= char_next;
            end_reg  <= is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            cnt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (emit)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (is_last)
                begin
                    busy_reg <= 1'b0;
                end
            end
            if (emit)
            begin
                valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = valid_reg;
    assign out_char  = char_reg;
    assign frame_end = end_reg;

endmodule

// ----- rtl/core/dfss_checker.sv -----
// ----------------------------------------------------------------------------
// dfss_checker
// Port-level checks on the character stream of the frame serializer.
// ----------------------------------------------------------------------------
module dfss_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tlast
);
    import dfss_pkg::*;

    logic in_frame_reg;

    // Tracks whether the next character handed over is inside a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_frame_reg <= 1'b0;
        end
        else if (m_axis_tvalid && m_axis_tready)
        begin
            in_frame_reg <= !m_axis_tlast;
        end
    end

    a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped while stalled");

    a_data_holds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

    a_frame_start: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tready && !in_frame_reg |-> m_axis_tdata == CHAR_D)
        else $error("frame does not start with D");

    a_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tdata == CHAR_NL)
        else $error("frame end is not a newline");

    a_newline_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata == CHAR_NL |-> m_axis_tlast)
        else $error("newline inside a frame");

endmodule

bind display_frame_shadow_serializer_unit dfss_checker u_dfss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
);
